### rtl/core/twadc_pkg.sv
package twadc_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_HIGH = 2'd2,
      PH_LOW  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ACT_TICK        = 2'd0,
      ACT_READ_SAMPLE = 2'd1,
      ACT_WRITE_CFG   = 2'd2,
      ACT_READ_CFG    = 2'd3
   } action_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_HALF_PERIOD   = 2'd0;
   localparam logic [1:0] CSR_READY_TIMEOUT = 2'd1;

   localparam logic [9:0]  HALF_PERIOD_RESET   = 10'd1;
   localparam logic [23:0] READY_TIMEOUT_RESET = 24'd750000;

   // Data line setting: bit 1 drive enable, bit 0 level.
   localparam logic [1:0] LINE_RELEASED   = 2'b01;
   localparam logic [1:0] LINE_DRIVE_HIGH = 2'b11;

   localparam logic [7:0] CMD_WRITE = 8'h65;
   localparam logic [7:0] CMD_READ  = 8'h56;

   localparam logic [5:0] SAMPLE_CLOCKS    = 6'd27;
   localparam logic [5:0] CFG_CLOCKS       = 6'd46;
   localparam logic [5:0] SAMPLE_KEEP      = 6'd24;
   localparam logic [5:0] CFG_PREAMBLE     = 6'd29;
   localparam logic [5:0] CMD_LAST_CLOCK   = 6'd35;
   localparam logic [5:0] TURNAROUND_CLOCK = 6'd36;
   localparam logic [5:0] RDBK_FIRST_CLOCK = 6'd37;
   localparam logic [5:0] DATA_LAST_CLOCK  = 6'd44;

   // Line setting for clock number clk_num of a sequence.
   function automatic logic [1:0] line_for_clock(action_type op, logic [5:0] clk_num,
                                                logic [7:0] data_byte);
      logic [7:0] cmd;
      logic [5:0] cmd_pos;
      logic [5:0] data_pos;
      cmd      = (op == ACT_WRITE_CFG) ? CMD_WRITE : CMD_READ;
      cmd_pos  = CMD_LAST_CLOCK - clk_num;
      data_pos = DATA_LAST_CLOCK - clk_num;
      if (op == ACT_READ_SAMPLE || clk_num < CFG_PREAMBLE) begin
         return LINE_RELEASED;
      end
      if (clk_num <= CMD_LAST_CLOCK) begin
         return {1'b1, cmd[cmd_pos[2:0]]};
      end
      if (clk_num == TURNAROUND_CLOCK) begin
         return {1'b1, (op == ACT_WRITE_CFG) ? cmd[0] : 1'b1};
      end
      if (op != ACT_WRITE_CFG) begin
         return LINE_RELEASED;
      end
      if (clk_num <= DATA_LAST_CLOCK) begin
         return {1'b1, data_byte[data_pos[2:0]]};
      end
      return {1'b1, data_byte[0]};
   endfunction

endpackage

### rtl/core/two_wire_adc_interface_unit.sv
// Channel | Direction | Beat contents
// req_    | in        | action, config_byte, data_line_level (one tick)
// rsp_    | out       | line levels, busy, done, status, sample, readback
// csr_    | in        | register index and write data
//
// Each req beat is one tick of the converter timing and produces exactly one
// rsp beat. The sequencer advances in the cycle a beat is accepted and the
// result is held in an output register, so a beat can be taken every cycle
// as long as the rsp side takes beats.
// req_ready is high whenever the output register is empty or is being taken.
// Reset is synchronous and returns the sequencer to idle with the clock line
// low and the data line released; register writes are always accepted.
module two_wire_adc_interface_unit #(
   parameter int ADC_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  twadc_pkg::action_type          req_action,
   input  logic [7:0]                     req_config_byte,
   input  logic                           req_data_line_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_clock_level,
   output logic                           rsp_data_drive_level,
   output logic                           rsp_data_drive_enable,
   output logic                           rsp_busy_res,
   output logic                           rsp_done_res,
   output logic                           rsp_status,
   output logic signed [23:0]             rsp_sample_value,
   output logic [7:0]                     rsp_config_readback,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [23:0]                    csr_data
);
   import twadc_pkg::*;

   localparam int SHIFT_AMT = 24 - ADC_BITS;

   // Configuration registers.
   logic [9:0]  half_period_ff;
   logic [23:0] ready_timeout_ff;

   // Sequencer state.
   phase_type   phase_ff, phase_in;
   action_type  operation_ff, operation_in;
   logic [5:0]  bit_counter_ff, bit_counter_in;
   logic [9:0]  level_tick_ff, level_tick_in;
   logic [23:0] ready_wait_ff, ready_wait_in;
   logic [23:0] shift_ff, shift_in;
   logic        clock_out_ff, clock_out_in;
   logic [1:0]  data_out_ff, data_out_in;

   // Result register.
   logic        rsp_valid_ff;
   logic        done_in, status_in;
   logic [23:0] sample_in;
   logic [7:0]  readback_in;
   logic        rsp_clock_ff, rsp_dlevel_ff, rsp_denable_ff, rsp_busy_ff;
   logic        rsp_done_ff, rsp_status_ff;
   logic [23:0] rsp_sample_ff;
   logic [7:0]  rsp_readback_ff;

   logic        req_fire;
   logic [9:0]  half_period;
   logic [23:0] ready_timeout;
   logic        level_done;
   logic [23:0] ready_wait_inc;
   logic        wait_expired;
   logic [5:0]  bit_inc;
   logic [5:0]  total_clocks;
   logic        seq_end;
   logic [23:0] shift_with_line;
   logic [23:0] reduced_sample;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // A zero half period or timeout behaves as one tick.
   assign half_period    = (half_period_ff == '0) ? 10'd1 : half_period_ff;
   assign ready_timeout  = (ready_timeout_ff == '0) ? 24'd1 : ready_timeout_ff;
   assign level_done     = level_tick_ff >= half_period;
   assign ready_wait_inc = ready_wait_ff + 24'd1;
   assign wait_expired   = ready_wait_inc >= ready_timeout;
   assign bit_inc        = bit_counter_ff + 6'd1;
   assign total_clocks   = (operation_ff == ACT_READ_SAMPLE) ? SAMPLE_CLOCKS : CFG_CLOCKS;
   assign seq_end        = bit_inc >= total_clocks;
   assign shift_with_line = {shift_ff[22:0], req_data_line_level};
   assign reduced_sample  = 24'($signed(shift_ff) >>> SHIFT_AMT);

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= HALF_PERIOD_RESET;
         ready_timeout_ff <= READY_TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_HALF_PERIOD) begin
            half_period_ff <= csr_data[9:0];
         end else if (csr_index == CSR_READY_TIMEOUT) begin
            ready_timeout_ff <= csr_data;
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_action != ACT_TICK) begin
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!req_data_line_level) begin
               phase_in = PH_HIGH;
            end else if (wait_expired) begin
               phase_in = PH_IDLE;
            end
         end
         PH_HIGH: begin
            if (level_done) begin
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            if (level_done) begin
               phase_in = seq_end ? PH_IDLE : PH_HIGH;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Datapath and result fields.
   always_comb begin
      operation_in   = operation_ff;
      bit_counter_in = bit_counter_ff;
      level_tick_in  = level_tick_ff;
      ready_wait_in  = ready_wait_ff;
      shift_in       = shift_ff;
      clock_out_in   = clock_out_ff;
      data_out_in    = data_out_ff;
      done_in        = 1'b0;
      status_in      = 1'b0;
      sample_in      = '0;
      readback_in    = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_action != ACT_TICK) begin
               operation_in  = req_action;
               shift_in      = (req_action == ACT_WRITE_CFG) ? {16'd0, req_config_byte} : '0;
               clock_out_in  = 1'b0;
               data_out_in   = LINE_RELEASED;
               ready_wait_in = '0;
            end
         end
         PH_WAIT: begin
            if (!req_data_line_level) begin
               bit_counter_in = '0;
               level_tick_in  = 10'd1;
               clock_out_in   = 1'b1;
               data_out_in    = line_for_clock(operation_ff, 6'd0, shift_ff[7:0]);
            end else begin
               ready_wait_in = ready_wait_inc;
               if (wait_expired) begin
                  // Timeout leaves the clock high.
                  clock_out_in = 1'b1;
                  data_out_in  = LINE_RELEASED;
                  done_in      = 1'b1;
                  status_in    = 1'b1;
               end
            end
         end
         PH_HIGH: begin
            if (!level_done) begin
               level_tick_in = level_tick_ff + 10'd1;
            end else begin
               // Sample bits are taken as the clock falls.
               if (operation_ff == ACT_READ_SAMPLE && bit_counter_ff < SAMPLE_KEEP) begin
                  shift_in = shift_with_line;
               end
               clock_out_in  = 1'b0;
               level_tick_in = 10'd1;
            end
         end
         PH_LOW: begin
            if (!level_done) begin
               level_tick_in = level_tick_ff + 10'd1;
            end else begin
               // Read-back bits are taken at the end of the low level.
               if (operation_ff == ACT_READ_CFG && bit_counter_ff >= RDBK_FIRST_CLOCK &&
                   bit_counter_ff <= DATA_LAST_CLOCK) begin
                  shift_in = shift_with_line;
               end
               bit_counter_in = bit_inc;
               if (seq_end) begin
                  done_in      = 1'b1;
                  clock_out_in = 1'b0;
                  if (operation_ff == ACT_READ_SAMPLE) begin
                     sample_in   = reduced_sample;
                     data_out_in = LINE_DRIVE_HIGH;
                  end else begin
                     if (operation_ff == ACT_READ_CFG) begin
                        readback_in = shift_in[7:0];
                     end
                     data_out_in = LINE_RELEASED;
                  end
               end else begin
                  clock_out_in  = 1'b1;
                  level_tick_in = 10'd1;
                  data_out_in   = line_for_clock(operation_ff, bit_inc, shift_ff[7:0]);
               end
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         operation_ff   <= ACT_TICK;
         bit_counter_ff <= '0;
         level_tick_ff  <= '0;
         ready_wait_ff  <= '0;
         shift_ff       <= '0;
         clock_out_ff   <= 1'b0;
         data_out_ff    <= LINE_RELEASED;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         operation_ff   <= operation_in;
         bit_counter_ff <= bit_counter_in;
         level_tick_ff  <= level_tick_in;
         ready_wait_ff  <= ready_wait_in;
         shift_ff       <= shift_in;
         clock_out_ff   <= clock_out_in;
         data_out_ff    <= data_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_clock_ff    <= clock_out_in;
         rsp_dlevel_ff   <= data_out_in[0];
         rsp_denable_ff  <= data_out_in[1];
         rsp_busy_ff     <= (phase_in != PH_IDLE);
         rsp_done_ff     <= done_in;
         rsp_status_ff   <= status_in;
         rsp_sample_ff   <= sample_in;
         rsp_readback_ff <= readback_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_clock_level       = rsp_clock_ff;
   assign rsp_data_drive_level  = rsp_dlevel_ff;
   assign rsp_data_drive_enable = rsp_denable_ff;
   assign rsp_busy_res          = rsp_busy_ff;
   assign rsp_done_res          = rsp_done_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_sample_value      = rsp_sample_ff;
   assign rsp_config_readback   = rsp_readback_ff;

   // A completed sequence is never reported as still busy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff)
      else $error("done reported while busy");

   // A timeout is only flagged with done and leaves the clock line high.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_done_ff && rsp_clock_ff))
      else $error("timeout status without done or with clock low");

   // Sample and readback fields only carry data on a done beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_sample_ff != '0 || rsp_readback_ff != '0)) |-> rsp_done_ff)
      else $error("result data outside a done beat");

   // The level counter is never zero while a clock level is being held.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HIGH || phase_ff == PH_LOW) |-> (level_tick_ff != '0))
      else $error("level counter cleared inside a bit");

endmodule

### bench/tb_two_wire_adc_interface_unit.sv
module tb_two_wire_adc_interface_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import twadc_pkg::*;

   localparam int SAMPLE_BITS  = 24;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int LONG_HOLD    = 200;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_BEATS  = 30;

   // Indexes with no register behind them; writes there must change nothing.
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   // One tick offered to the block, and the line levels and status it returns.
   typedef struct packed {
      action_type action;
      logic [7:0] config_byte;
      logic       data_line;
   } tick_beat_t;

   typedef struct packed {
      logic              clock_level;
      logic              drive_level;
      logic              drive_enable;
      logic              busy;
      logic              done;
      logic              status;
      logic signed [23:0] sample;
      logic [7:0]        readback;
   } line_state_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   action_type        req_action = ACT_TICK;
   logic [7:0]        req_config_byte = 8'h00;
   logic              req_data_line_level = 1'b1;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_clock_level;
   logic              rsp_data_drive_level;
   logic              rsp_data_drive_enable;
   logic              rsp_busy_res;
   logic              rsp_done_res;
   logic              rsp_status;
   logic signed [23:0] rsp_sample_value;
   logic [7:0]        rsp_config_readback;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = CSR_HALF_PERIOD;
   logic [23:0]       csr_data = 24'h000000;

   two_wire_adc_interface_unit #(
      .ADC_BITS(SAMPLE_BITS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_config_byte      (req_config_byte),
      .req_data_line_level  (req_data_line_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_clock_level      (rsp_clock_level),
      .rsp_data_drive_level (rsp_data_drive_level),
      .rsp_data_drive_enable(rsp_data_drive_enable),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_status           (rsp_status),
      .rsp_sample_value     (rsp_sample_value),
      .rsp_config_readback  (rsp_config_readback),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #5 clock = ~clock;

   // Ticks waiting to be offered, and line states waiting to be seen.
   tick_beat_t  tick_queue[$];
   line_state_t expected_line_states[$];

   // Flow control knobs, set per phase by the stimulus process.
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int hold_requested = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   logic req_beat_taken = 1'b0;

   int ticks_queued   = 0;
   int beats_accepted = 0;
   int results_seen   = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int samples_done   = 0;
   int cfg_writes_done = 0;
   int cfg_reads_done = 0;
   int timeouts_done  = 0;

   // Sequencer state as the predictor tracks it, plus its register copies.
   phase_type   seq_phase = PH_IDLE;
   action_type  seq_op = ACT_TICK;
   logic [5:0]  seq_clock_num = '0;
   logic [9:0]  level_ticks = '0;
   logic [23:0] ready_wait = '0;
   logic [23:0] shift_reg = '0;
   logic        clk_out = 1'b0;
   logic [1:0]  data_out = LINE_RELEASED;
   logic [9:0]  half_period_reg = HALF_PERIOD_RESET;
   logic [23:0] ready_timeout_reg = READY_TIMEOUT_RESET;

   // Data line setting for a given clock of a sequence: bit 1 enables the driver.
   function automatic logic [1:0] line_setting(action_type op, logic [5:0] clk_num,
                                               logic [7:0] data_byte);
      logic [7:0] cmd;
      cmd = (op == ACT_WRITE_CFG) ? CMD_WRITE : CMD_READ;
      if (op == ACT_READ_SAMPLE || clk_num < CFG_PREAMBLE) begin
         line_setting = LINE_RELEASED;
      end else if (clk_num <= CMD_LAST_CLOCK) begin
         line_setting = {1'b1, cmd[3'(CMD_LAST_CLOCK - clk_num)]};
      end else if (clk_num == TURNAROUND_CLOCK) begin
         line_setting = {1'b1, (op == ACT_WRITE_CFG) ? cmd[0] : 1'b1};
      end else if (op != ACT_WRITE_CFG) begin
         line_setting = LINE_RELEASED;
      end else if (clk_num <= DATA_LAST_CLOCK) begin
         line_setting = {1'b1, data_byte[3'(DATA_LAST_CLOCK - clk_num)]};
      end else begin
         line_setting = {1'b1, data_byte[0]};
      end
   endfunction

   // Advances the predicted sequencer by one tick and returns the line state.
   function line_state_t advance_sequencer(tick_beat_t beat);
      logic [9:0]  hp;
      logic [23:0] limit_ticks;
      logic [5:0]  last_clock;
      line_state_t res;
      hp          = (half_period_reg == '0) ? 10'd1 : half_period_reg;
      limit_ticks = (ready_timeout_reg == '0) ? 24'd1 : ready_timeout_reg;
      res.done     = 1'b0;
      res.status   = 1'b0;
      res.sample   = '0;
      res.readback = '0;
      case (seq_phase)
         PH_IDLE: begin
            if (beat.action != ACT_TICK) begin
               seq_op     = beat.action;
               shift_reg  = (beat.action == ACT_WRITE_CFG) ? {16'h0000, beat.config_byte} : '0;
               clk_out    = 1'b0;
               data_out   = LINE_RELEASED;
               ready_wait = '0;
               seq_phase  = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!beat.data_line) begin
               seq_phase     = PH_HIGH;
               seq_clock_num = '0;
               level_ticks   = 10'd1;
               clk_out       = 1'b1;
               data_out      = line_setting(seq_op, '0, shift_reg[7:0]);
            end else begin
               ready_wait = ready_wait + 24'd1;
               if (ready_wait >= limit_ticks) begin
                  // The converter never answered: the clock is left high.
                  clk_out    = 1'b1;
                  data_out   = LINE_RELEASED;
                  seq_phase  = PH_IDLE;
                  res.done   = 1'b1;
                  res.status = 1'b1;
                  timeouts_done++;
               end
            end
         end
         PH_HIGH: begin
            if (level_ticks < hp) begin
               level_ticks = level_ticks + 10'd1;
            end else begin
               if (seq_op == ACT_READ_SAMPLE && seq_clock_num < SAMPLE_KEEP) begin
                  shift_reg = {shift_reg[22:0], beat.data_line};
               end
               clk_out     = 1'b0;
               level_ticks = 10'd1;
               seq_phase   = PH_LOW;
            end
         end
         PH_LOW: begin
            if (level_ticks < hp) begin
               level_ticks = level_ticks + 10'd1;
            end else begin
               last_clock = (seq_op == ACT_READ_SAMPLE) ? SAMPLE_CLOCKS : CFG_CLOCKS;
               if (seq_op == ACT_READ_CFG && seq_clock_num >= RDBK_FIRST_CLOCK &&
                   seq_clock_num <= DATA_LAST_CLOCK) begin
                  shift_reg = {shift_reg[22:0], beat.data_line};
               end
               seq_clock_num = seq_clock_num + 6'd1;
               if (seq_clock_num >= last_clock) begin
                  seq_phase = PH_IDLE;
                  res.done  = 1'b1;
                  clk_out   = 1'b0;
                  if (seq_op == ACT_READ_SAMPLE) begin
                     res.sample = $signed(shift_reg) >>> (24 - SAMPLE_BITS);
                     data_out   = LINE_DRIVE_HIGH;
                     samples_done++;
                  end else begin
                     if (seq_op == ACT_READ_CFG) begin
                        res.readback = shift_reg[7:0];
                        cfg_reads_done++;
                     end else begin
                        cfg_writes_done++;
                     end
                     data_out = LINE_RELEASED;
                  end
               end else begin
                  seq_phase   = PH_HIGH;
                  clk_out     = 1'b1;
                  level_ticks = 10'd1;
                  data_out    = line_setting(seq_op, seq_clock_num, shift_reg[7:0]);
               end
            end
         end
         default: seq_phase = PH_IDLE;
      endcase
      res.clock_level  = clk_out;
      res.drive_level  = data_out[0];
      res.drive_enable = data_out[1];
      res.busy         = (seq_phase != PH_IDLE);
      return res;
   endfunction

   function void apply_register_write(logic [1:0] reg_index, logic [23:0] value);
      case (reg_index)
         CSR_HALF_PERIOD:   half_period_reg = value[9:0];
         CSR_READY_TIMEOUT: ready_timeout_reg = value;
         default: ;
      endcase
   endfunction

   function automatic int effective_half_period();
      return (half_period_reg == '0) ? 1 : int'(half_period_reg);
   endfunction

   function automatic int effective_timeout();
      return (ready_timeout_reg == '0) ? 1 : int'(ready_timeout_reg);
   endfunction

   function automatic action_type any_action();
      return action_type'(2'($urandom_range(3, 0)));
   endfunction

   // Sender: a new tick goes out at the falling edge once the last one was taken.
   always @(negedge clock) begin : drive_ticks
      tick_beat_t beat;
      if (!reset && (!req_valid || req_beat_taken)) begin
         if (tick_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            beat = tick_queue.pop_front();
            req_valid           <= 1'b1;
            req_action          <= beat.action;
            req_config_byte     <= beat.config_byte;
            req_data_line_level <= beat.data_line;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
   always @(negedge clock) begin : drive_rsp_ready
      if (hold_served != hold_requested) begin
         hold_served = hold_requested;
         hold_left   = LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // Every accepted tick is run through the predictor right at its edge.
   always @(posedge clock) begin : predict_ticks
      tick_beat_t beat;
      if (!reset && req_valid && req_ready) begin
         beat.action      = req_action;
         beat.config_byte = req_config_byte;
         beat.data_line   = req_data_line_level;
         expected_line_states.push_back(advance_sequencer(beat));
         beats_accepted++;
         req_beat_taken <= 1'b1;
      end else begin
         req_beat_taken <= 1'b0;
      end
      if (!reset && csr_valid && csr_ready) begin
         apply_register_write(csr_index, csr_data);
      end
   end

   always @(posedge clock) begin : check_results
      line_state_t want;
      line_state_t got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.clock_level  = rsp_clock_level;
         got.drive_level  = rsp_data_drive_level;
         got.drive_enable = rsp_data_drive_enable;
         got.busy         = rsp_busy_res;
         got.done         = rsp_done_res;
         got.status       = rsp_status;
         got.sample       = rsp_sample_value;
         got.readback     = rsp_config_readback;
         if (expected_line_states.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("result beat %0d arrived with nothing expected", results_seen);
            end
         end else begin
            want = expected_line_states.pop_front();
            if (got.clock_level !== want.clock_level || got.drive_level !== want.drive_level ||
                got.drive_enable !== want.drive_enable || got.busy !== want.busy ||
                got.done !== want.done || got.status !== want.status ||
                got.sample !== want.sample || got.readback !== want.readback) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("beat %0d: clk/dat/en/busy/done/st expected %b%b%b%b%b%b got %b%b%b%b%b%b",
                           results_seen, want.clock_level, want.drive_level, want.drive_enable,
                           want.busy, want.done, want.status, got.clock_level, got.drive_level,
                           got.drive_enable, got.busy, got.done, got.status);
                  $display("   sample expected %h got %h, readback expected %h got %h",
                           want.sample, got.sample, want.readback, got.readback);
               end
            end
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit, %0d results outstanding",
                  expected_line_states.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_tick(action_type action, logic [7:0] byte_val, logic level);
      tick_beat_t beat;
      beat.action      = action;
      beat.config_byte = byte_val;
      beat.data_line   = level;
      tick_queue.push_back(beat);
      ticks_queued++;
   endtask

   // A whole sequence from the converter's side: start, ready waits, the
   // ready-low tick and then the clocked bits. clock_bits[45 - n] is the line
   // level held during clock n. A wait count that reaches the timeout makes a
   // timed-out sequence; cut_short ends it early, leaving the block busy.
   task automatic queue_sequence(action_type op, logic [7:0] byte_val, logic [45:0] clock_bits,
                                 int waits, bit cut_short);
      int hp;
      int span;
      int t;
      hp   = effective_half_period();
      span = ((op == ACT_READ_SAMPLE) ? int'(SAMPLE_CLOCKS) : int'(CFG_CLOCKS)) * 2 * hp;
      queue_tick(op, byte_val, 1'($urandom));
      repeat (waits) queue_tick(any_action(), 8'($urandom), 1'b1);
      if (waits < effective_timeout()) begin
         queue_tick(any_action(), 8'($urandom), 1'b0);
         if (cut_short) begin
            span = $urandom_range(span - 1, 0);
         end
         for (t = 0; t < span; t++) begin
            queue_tick(any_action(), 8'($urandom), clock_bits[6'(45 - t / (2 * hp))]);
         end
      end
   endtask

   // Enough quiet ticks to finish whatever sequence may still be running.
   task automatic queue_recovery();
      queue_tick(ACT_TICK, 8'($urandom), 1'b0);
      repeat (int'(CFG_CLOCKS) * 2 * effective_half_period()) begin
         queue_tick(ACT_TICK, 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (tick_queue.size() != 0 || req_valid || expected_line_states.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Drains all traffic and leaves the sequencer idle so registers may change.
   task automatic settle();
      wait_drained();
      while (seq_phase != PH_IDLE) begin
         queue_recovery();
         wait_drained();
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] reg_index, logic [23:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(logic [9:0] half_period, logic [23:0] timeout);
      write_register(CSR_HALF_PERIOD, {14'($urandom), half_period});
      write_register(CSR_READY_TIMEOUT, timeout);
   endtask

   // Mostly complete sequences with random content, some idle ticks, and a
   // share of noise and truncated sequences, each followed by a recovery run.
   // Halfway through, the sender waits until every result is back.
   task automatic run_random_phase(int send_pct, int rsp_pct, logic [9:0] half_period,
                                   logic [23:0] timeout, bit long_hold);
      int first;
      int kind;
      bit paused;
      settle();
      set_timing(half_period, timeout);
      send_idle_pct = send_pct;
      stall_pct     = rsp_pct;
      if (long_hold) begin
         hold_requested++;
      end
      first  = ticks_queued;
      paused = 1'b0;
      while (ticks_queued - first < PHASE_BEATS) begin
         if (!paused && ticks_queued - first > PHASE_BEATS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         kind = $urandom_range(99, 0);
         if (kind < 55) begin
            queue_sequence(action_type'(2'($urandom_range(3, 1))), 8'($urandom),
                           46'({$urandom, $urandom}),
                           $urandom_range((effective_timeout() > 6) ? 5 : effective_timeout() - 1, 0),
                           1'b0);
         end else if (kind < 65 && effective_timeout() <= 64) begin
            queue_sequence(action_type'(2'($urandom_range(3, 1))), 8'($urandom),
                           46'({$urandom, $urandom}), effective_timeout(), 1'b0);
         end else if (kind < 80) begin
            repeat ($urandom_range(4, 1)) queue_tick(ACT_TICK, 8'($urandom), 1'($urandom));
         end else if (kind < 90) begin
            repeat ($urandom_range(6, 1)) queue_tick(any_action(), 8'($urandom), 1'($urandom));
            queue_recovery();
         end else begin
            queue_sequence(action_type'(2'($urandom_range(3, 1))), 8'($urandom),
                           46'({$urandom, $urandom}), 0, 1'b1);
            queue_recovery();
         end
      end
      settle();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: tick-only beats, sample extremes, both command bytes.
      queue_tick(ACT_TICK, 8'h00, 1'b0);
      queue_tick(ACT_TICK, 8'hFF, 1'b1);
      queue_sequence(ACT_READ_SAMPLE, 8'hFF, {24'h800000, 22'd0}, 0, 1'b0);
      queue_sequence(ACT_READ_SAMPLE, 8'h00, {24'h7FFFFF, 22'h3FFFFF}, 3, 1'b0);
      queue_sequence(ACT_WRITE_CFG, 8'hFF, '0, 1, 1'b0);
      queue_sequence(ACT_WRITE_CFG, 8'h00, '1, 0, 1'b0);
      queue_sequence(ACT_READ_CFG, 8'h00, {37'd0, 8'hA5, 1'b0}, 2, 1'b0);
      settle();

      // Zero half period and zero timeout both behave as one tick.
      set_timing(10'd0, 24'd0);
      queue_sequence(ACT_READ_CFG, 8'h3C, {37'h1FFFFFFFFF, 8'h5A, 1'b1}, 1, 1'b0);
      queue_sequence(ACT_READ_SAMPLE, 8'($urandom), '1, 0, 1'b0);
      queue_sequence(ACT_READ_CFG, 8'hC3, {37'h1FFFFFFFFF, 8'h5A, 1'b1}, 0, 1'b0);
      settle();
      write_register(CSR_SPARE_LO, 24'($urandom));
      write_register(CSR_SPARE_HI, 24'hFFFFFF);
      queue_sequence(ACT_WRITE_CFG, 8'($urandom), '0, 0, 1'b0);
      settle();

      // The slowest settings start a sample read; while the first clock is
      // still high the half period drops back to one tick, which ends that
      // level on the next tick and lets the read finish quickly.
      set_timing(10'd1023, 24'hFFFFFF);
      queue_tick(ACT_READ_SAMPLE, 8'($urandom), 1'b1);
      repeat (2) queue_tick(ACT_TICK, 8'($urandom), 1'b1);
      queue_tick(ACT_TICK, 8'($urandom), 1'b0);
      repeat (40) queue_tick(any_action(), 8'($urandom), 1'($urandom));
      wait_drained();
      set_timing(10'd1, READY_TIMEOUT_RESET);
      settle();

      run_random_phase(0, 0, 10'd1, 24'd4, 1'b1);
      run_random_phase(85, 0, 10'd2, 24'd1, 1'b0);
      run_random_phase(0, 85, 10'd1, READY_TIMEOUT_RESET, 1'b1);
      run_random_phase(15, 15, 10'd3, 24'd12, 1'b0);

      settle();
      repeat (10) @(posedge clock);
      if (expected_line_states.size() != 0) begin
         mismatch_count += expected_line_states.size();
         $display("%0d expected result beats never arrived", expected_line_states.size());
      end
      $display("Covered %0d tick beats: %0d sample reads, %0d config writes, %0d config reads,",
               beats_accepted, samples_done, cfg_writes_done, cfg_reads_done);
      $display("%0d ready timeouts, half periods 0 to 1023, under four flow control mixes.",
               timeouts_done);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
